// ----- rtl/ill_pkg.sv -----
package ill_pkg;

    localparam int DEF_SECTION_NAME_MAX = 255;
    localparam int DEF_OPTION_NAME_MAX  = 255;
    localparam int DEF_FLAG_NAME_MAX    = 255;
    localparam int DEF_FLAG_COUNT_MAX   = 32;
    localparam int DEF_VALUE_MAX        = 1023;

    localparam int BLANK_W = 10;

    localparam logic [1:0] ACT_DATA    = 2'd0;
    localparam logic [1:0] ACT_END     = 2'd1;
    localparam logic [1:0] ACT_RESTART = 2'd2;

    localparam logic [3:0] EV_SECT_CHAR  = 4'd0;
    localparam logic [3:0] EV_SECT_END   = 4'd1;
    localparam logic [3:0] EV_FLAG_CHAR  = 4'd2;
    localparam logic [3:0] EV_FLAG_END   = 4'd3;
    localparam logic [3:0] EV_OPT_CHAR   = 4'd4;
    localparam logic [3:0] EV_OPT_END    = 4'd5;
    localparam logic [3:0] EV_VAL_CHAR   = 4'd6;
    localparam logic [3:0] EV_PARAM_END  = 4'd7;
    localparam logic [3:0] EV_FLAGS_ONLY = 4'd8;
    localparam logic [3:0] EV_DONE       = 4'd9;
    localparam logic [3:0] EV_ERROR      = 4'd10;

    localparam logic [3:0] ERR_NONE       = 4'd0;
    localparam logic [3:0] ERR_EARLY_END  = 4'd1;
    localparam logic [3:0] ERR_BAD_NL     = 4'd2;
    localparam logic [3:0] ERR_SECT_EMPTY = 4'd3;
    localparam logic [3:0] ERR_SECT_LONG  = 4'd4;
    localparam logic [3:0] ERR_FLAG_EMPTY = 4'd5;
    localparam logic [3:0] ERR_FLAG_LONG  = 4'd6;
    localparam logic [3:0] ERR_FLAG_MANY  = 4'd7;
    localparam logic [3:0] ERR_OPT_EMPTY  = 4'd8;
    localparam logic [3:0] ERR_OPT_LONG   = 4'd9;
    localparam logic [3:0] ERR_VAL_LONG   = 4'd10;

    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LBRK   = 8'h5B;
    localparam logic [7:0] CH_RBRK   = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    typedef enum logic [2:0] {
        M_LINE,
        M_COMMENT,
        M_SECT,
        M_FLAGLIST,
        M_AFTER_FLAGS,
        M_NAME,
        M_VAL,
        M_STOPPED
    } t_mode;

    typedef struct packed {
        t_mode              mode;
        logic               skip;
        logic               negated;
        logic [BLANK_W-1:0] pending;
    } t_ctl;

    localparam t_ctl CTL_RESET = '{mode: M_LINE, skip: 1'b1, negated: 1'b0, pending: '0};

    typedef struct packed {
        logic [3:0]         ev;
        logic [7:0]         tbyte;
        logic [BLANK_W-1:0] blanks;
        logic [3:0]         err;
    } t_payload;

    typedef struct packed {
        logic     valid;
        t_payload data;
    } t_result;

    function automatic logic is_ws(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB || ch == CH_VT || ch == CH_FF || ch == CH_CR;
    endfunction

    function automatic logic is_blank(input logic [7:0] ch);
        return ch == CH_SPACE || ch == CH_TAB;
    endfunction

    function automatic t_result mk_res(input logic [3:0] ev, input logic [7:0] b,
                                       input logic [BLANK_W-1:0] bl, input logic [3:0] e);
        t_result r;
        r.valid       = 1'b1;
        r.data.ev     = ev;
        r.data.tbyte  = b;
        r.data.blanks = bl;
        r.data.err    = e;
        return r;
    endfunction

endpackage

// ----- rtl/ill_step.sv -----
module ill_step #(
    parameter int SECTION_NAME_MAX = ill_pkg::DEF_SECTION_NAME_MAX,
    parameter int OPTION_NAME_MAX  = ill_pkg::DEF_OPTION_NAME_MAX,
    parameter int FLAG_NAME_MAX    = ill_pkg::DEF_FLAG_NAME_MAX,
    parameter int FLAG_COUNT_MAX   = ill_pkg::DEF_FLAG_COUNT_MAX,
    parameter int VALUE_MAX        = ill_pkg::DEF_VALUE_MAX,
    parameter int LEN_W            = 13,
    parameter int FC_W             = 6
) (
    input  logic [1:0]      i_action,
    input  logic [7:0]      i_byte,
    input  ill_pkg::t_ctl   i_ctl,
    input  logic [LEN_W-1:0] i_len,
    input  logic [FC_W-1:0] i_flags,
    output ill_pkg::t_ctl   o_ctl,
    output logic [LEN_W-1:0] o_len,
    output logic [FC_W-1:0] o_flags,
    output ill_pkg::t_result o_res
);
    import ill_pkg::*;

    t_ctl             n_ctl;
    logic [LEN_W-1:0] n_len;
    logic [FC_W-1:0]  n_flags;
    t_result          res;
    logic             do_opt;
    logic             do_name;
    logic [LEN_W-1:0] nm_limit;
    logic [3:0]       nm_ev;
    logic [3:0]       nm_err;

    always_comb begin
        n_ctl    = i_ctl;
        n_len    = i_len;
        n_flags  = i_flags;
        res      = '0;
        do_opt   = 1'b0;
        do_name  = 1'b0;
        nm_limit = '0;
        nm_ev    = EV_OPT_CHAR;
        nm_err   = ERR_NONE;

        if (i_action == ACT_RESTART) begin
            n_ctl   = CTL_RESET;
            n_len   = '0;
            n_flags = '0;
        end else if (i_action == ACT_END && i_ctl.mode != M_STOPPED) begin
            if (i_ctl.mode == M_LINE || i_ctl.mode == M_COMMENT) begin
                n_ctl.mode = M_STOPPED;
                res = mk_res(EV_DONE, 8'd0, '0, ERR_NONE);
            end else if (i_ctl.mode == M_VAL) begin
                n_ctl.mode    = M_LINE;
                n_ctl.skip    = 1'b1;
                n_ctl.pending = '0;
                res = mk_res(EV_PARAM_END, 8'd0, '0, ERR_NONE);
            end else begin
                n_ctl.mode = M_STOPPED;
                res = mk_res(EV_ERROR, 8'd0, '0, ERR_EARLY_END);
            end
        end else if (i_action == ACT_DATA) begin
            unique case (i_ctl.mode)
                M_LINE: begin
                    if (is_ws(i_byte) || i_byte == CH_NL) begin
                    end else if (i_byte == CH_NUL) begin
                        n_ctl.mode = M_STOPPED;
                        res = mk_res(EV_DONE, 8'd0, '0, ERR_NONE);
                    end else begin
                        n_len = '0;
                        case (i_byte) inside
                            CH_SEMI, CH_HASH: begin
                                n_ctl.mode = M_COMMENT;
                            end
                            CH_LBRK: begin
                                n_ctl.mode = M_SECT;
                                n_ctl.skip = 1'b1;
                            end
                            CH_LBRACE: begin
                                n_ctl.mode = M_FLAGLIST;
                                n_ctl.skip = 1'b1;
                                n_flags    = '0;
                            end
                            default: begin
                                n_ctl.mode = M_NAME;
                                n_ctl.skip = 1'b0;
                                do_opt     = 1'b1;
                            end
                        endcase
                    end
                end
                M_COMMENT: begin
                    if (i_byte == CH_NL) begin
                        n_ctl.mode = M_LINE;
                        n_ctl.skip = 1'b1;
                    end else if (i_byte == CH_NUL) begin
                        n_ctl.mode = M_STOPPED;
                        res = mk_res(EV_DONE, 8'd0, '0, ERR_NONE);
                    end
                end
                M_SECT: begin
                    if (i_ctl.skip && is_ws(i_byte)) begin
                    end else if (is_blank(i_byte)) begin
                        n_ctl.skip = 1'b1;
                    end else begin
                        n_ctl.skip = 1'b0;
                        if (i_byte == CH_RBRK) begin
                            if (i_len == '0) begin
                                n_ctl.mode = M_STOPPED;
                                res = mk_res(EV_ERROR, 8'd0, '0, ERR_SECT_EMPTY);
                            end else if (i_len > LEN_W'(SECTION_NAME_MAX)) begin
                                n_ctl.mode = M_STOPPED;
                                res = mk_res(EV_ERROR, 8'd0, '0, ERR_SECT_LONG);
                            end else begin
                                n_ctl.mode = M_LINE;
                                n_ctl.skip = 1'b1;
                                res = mk_res(EV_SECT_END, 8'd0, '0, ERR_NONE);
                            end
                        end else if (i_byte == CH_NL) begin
                            n_ctl.mode = M_STOPPED;
                            res = mk_res(EV_ERROR, 8'd0, '0, ERR_BAD_NL);
                        end else begin
                            do_name  = 1'b1;
                            nm_limit = LEN_W'(SECTION_NAME_MAX);
                            nm_ev    = EV_SECT_CHAR;
                            nm_err   = ERR_SECT_LONG;
                        end
                    end
                end
                M_FLAGLIST: begin
                    if (i_ctl.skip && is_ws(i_byte)) begin
                    end else if (is_blank(i_byte)) begin
                        n_ctl.skip = 1'b1;
                    end else begin
                        n_ctl.skip = 1'b0;
                        if (i_byte == CH_NL) begin
                            n_ctl.mode = M_STOPPED;
                            res = mk_res(EV_ERROR, 8'd0, '0, ERR_BAD_NL);
                        end else if (i_byte == CH_COMMA || i_byte == CH_RBRACE) begin
                            if (i_len > LEN_W'(FLAG_NAME_MAX)) begin
                                n_ctl.mode = M_STOPPED;
                                res = mk_res(EV_ERROR, 8'd0, '0, ERR_FLAG_LONG);
                            end else if (i_len == '0 ||
                                         (i_len == LEN_W'(1) && i_ctl.negated)) begin
                                n_ctl.mode = M_STOPPED;
                                res = mk_res(EV_ERROR, 8'd0, '0, ERR_FLAG_EMPTY);
                            end else if (i_flags >= FC_W'(FLAG_COUNT_MAX)) begin
                                n_ctl.mode = M_STOPPED;
                                res = mk_res(EV_ERROR, 8'd0, '0, ERR_FLAG_MANY);
                            end else begin
                                n_flags    = i_flags + FC_W'(1);
                                n_len      = '0;
                                n_ctl.skip = 1'b1;
                                n_ctl.mode = (i_byte == CH_RBRACE) ? M_AFTER_FLAGS : M_FLAGLIST;
                                res = mk_res(EV_FLAG_END, 8'd0, '0, ERR_NONE);
                            end
                        end else begin
                            if (i_byte == CH_BANG) begin
                                n_ctl.skip = 1'b1;
                            end
                            do_name  = 1'b1;
                            nm_limit = LEN_W'(FLAG_NAME_MAX);
                            nm_ev    = EV_FLAG_CHAR;
                            nm_err   = ERR_FLAG_LONG;
                        end
                    end
                end
                M_AFTER_FLAGS: begin
                    if (is_ws(i_byte)) begin
                    end else if (i_byte == CH_NL) begin
                        n_ctl.mode = M_LINE;
                        n_ctl.skip = 1'b1;
                        res = mk_res(EV_FLAGS_ONLY, 8'd0, '0, ERR_NONE);
                    end else begin
                        n_ctl.mode = M_NAME;
                        n_len      = '0;
                        do_opt     = 1'b1;
                    end
                end
                M_NAME: begin
                    do_opt = 1'b1;
                end
                M_VAL: begin
                    if (i_ctl.skip && is_ws(i_byte)) begin
                    end else begin
                        n_ctl.skip = 1'b0;
                        if (i_byte == CH_NL) begin
                            n_ctl.mode    = M_LINE;
                            n_ctl.skip    = 1'b1;
                            n_ctl.pending = '0;
                            res = mk_res(EV_PARAM_END, 8'd0, '0, ERR_NONE);
                        end else if (i_len >= LEN_W'(VALUE_MAX)) begin
                            n_ctl.mode = M_STOPPED;
                            res = mk_res(EV_ERROR, 8'd0, '0, ERR_VAL_LONG);
                        end else begin
                            n_len = i_len + LEN_W'(1);
                            if (is_blank(i_byte)) begin
                                n_ctl.pending = i_ctl.pending + BLANK_W'(1);
                            end else begin
                                res = mk_res(EV_VAL_CHAR, i_byte, i_ctl.pending, ERR_NONE);
                                n_ctl.pending = '0;
                            end
                        end
                    end
                end
                M_STOPPED: begin
                end
                default: begin
                    n_ctl.mode = M_STOPPED;
                end
            endcase
        end

        // option name byte, shared by line start, after flags and name modes
        if (do_opt) begin
            if (n_ctl.skip && is_ws(i_byte)) begin
            end else if (is_blank(i_byte)) begin
                n_ctl.skip = 1'b1;
            end else begin
                n_ctl.skip = 1'b0;
                if (i_byte == CH_NL) begin
                    n_ctl.mode = M_STOPPED;
                    res = mk_res(EV_ERROR, 8'd0, '0, ERR_BAD_NL);
                end else if (i_byte == CH_EQ) begin
                    if (n_len == '0) begin
                        n_ctl.mode = M_STOPPED;
                        res = mk_res(EV_ERROR, 8'd0, '0, ERR_OPT_EMPTY);
                    end else if (n_len > LEN_W'(OPTION_NAME_MAX)) begin
                        n_ctl.mode = M_STOPPED;
                        res = mk_res(EV_ERROR, 8'd0, '0, ERR_OPT_LONG);
                    end else begin
                        n_ctl.mode    = M_VAL;
                        n_ctl.skip    = 1'b1;
                        n_len         = '0;
                        n_ctl.pending = '0;
                        res = mk_res(EV_OPT_END, 8'd0, '0, ERR_NONE);
                    end
                end else begin
                    do_name  = 1'b1;
                    nm_limit = LEN_W'(OPTION_NAME_MAX);
                    nm_ev    = EV_OPT_CHAR;
                    nm_err   = ERR_OPT_LONG;
                end
            end
        end

        // name byte with length limit
        if (do_name) begin
            if (n_len > nm_limit) begin
                n_ctl.mode = M_STOPPED;
                res = mk_res(EV_ERROR, 8'd0, '0, nm_err);
            end else begin
                if (n_len == '0) begin
                    n_ctl.negated = (i_byte == CH_BANG);
                end
                n_len = n_len + LEN_W'(1);
                res = mk_res(nm_ev, i_byte, '0, ERR_NONE);
            end
        end
    end

    assign o_ctl   = n_ctl;
    assign o_len   = n_len;
    assign o_flags = n_flags;
    assign o_res   = res;

endmodule

// ----- rtl/ini_line_lexer_core.sv -----
// Streaming INI lexer. One request (a data byte, end of input or restart) is taken
// per clock while s_axis_tready is high; the lexer mode, token length, flag count and
// held-back blank count are updated by one combinational step between the input
// register and the result register, so a sustained rate of one byte per cycle is
// reached while m_axis_tready is high; a result reaches the master side via both
// registers. The slave side keeps accepting while a result waits in the output register;
// it stalls only when the input and output registers are full and m_axis_tready is low.
module ini_line_lexer_core #(
    parameter int SECTION_NAME_MAX = ill_pkg::DEF_SECTION_NAME_MAX,
    parameter int OPTION_NAME_MAX  = ill_pkg::DEF_OPTION_NAME_MAX,
    parameter int FLAG_NAME_MAX    = ill_pkg::DEF_FLAG_NAME_MAX,
    parameter int FLAG_COUNT_MAX   = ill_pkg::DEF_FLAG_COUNT_MAX,
    parameter int VALUE_MAX        = ill_pkg::DEF_VALUE_MAX
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // data_byte
    input  logic [1:0]  s_axis_tuser,  // action
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,  // token_byte, blanks_before, error_code, zero pad
    output logic [3:0]  m_axis_tuser   // event_res
);
    import ill_pkg::*;

    localparam int NAME_MAX_A = (SECTION_NAME_MAX > OPTION_NAME_MAX) ?
                                SECTION_NAME_MAX : OPTION_NAME_MAX;
    localparam int NAME_MAX_B = (NAME_MAX_A > FLAG_NAME_MAX) ? NAME_MAX_A : FLAG_NAME_MAX;
    localparam int LEN_MAX    = (NAME_MAX_B > VALUE_MAX) ? NAME_MAX_B : VALUE_MAX;
    localparam int LEN_W      = $clog2(LEN_MAX + 2);
    localparam int FC_W       = $clog2(FLAG_COUNT_MAX + 1);

    logic             r_in_valid;
    logic [1:0]       r_in_action;
    logic [7:0]       r_in_byte;
    t_ctl             r_ctl;
    logic [LEN_W-1:0] r_len;
    logic [FC_W-1:0]  r_flags;
    logic             r_out_valid;
    t_payload         r_out;

    t_ctl             n_ctl;
    logic [LEN_W-1:0] n_len;
    logic [FC_W-1:0]  n_flags;
    t_result          n_res;

    logic advance;
    logic in_take;

    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    ill_step #(
        .SECTION_NAME_MAX (SECTION_NAME_MAX),
        .OPTION_NAME_MAX  (OPTION_NAME_MAX),
        .FLAG_NAME_MAX    (FLAG_NAME_MAX),
        .FLAG_COUNT_MAX   (FLAG_COUNT_MAX),
        .VALUE_MAX        (VALUE_MAX),
        .LEN_W            (LEN_W),
        .FC_W             (FC_W)
    ) u_step (
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .i_ctl    (r_ctl),
        .i_len    (r_len),
        .i_flags  (r_flags),
        .o_ctl    (n_ctl),
        .o_len    (n_len),
        .o_flags  (n_flags),
        .o_res    (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ctl       <= CTL_RESET;
            r_len       <= '0;
            r_flags     <= '0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_ctl   <= n_ctl;
                r_len   <= n_len;
                r_flags <= n_flags;
            end
            if (advance && n_res.valid) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_action <= s_axis_tuser;
            r_in_byte   <= s_axis_tdata;
        end
        if (advance && n_res.valid) begin
            r_out <= n_res.data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.ev;
    assign m_axis_tdata  = {2'b00, r_out.err, r_out.blanks, r_out.tbyte};

endmodule

// ----- rtl/ill_checker.sv -----
module ill_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);
    import ill_pkg::*;

    logic char_ev;

    assign char_ev = m_axis_tuser == EV_SECT_CHAR || m_axis_tuser == EV_FLAG_CHAR ||
                     m_axis_tuser == EV_OPT_CHAR || m_axis_tuser == EV_VAL_CHAR;

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // error code present exactly on error events
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == EV_ERROR) == (m_axis_tdata[21:18] != ERR_NONE)))
        else $error("error code does not match event");

    // token byte only on char events
    a_tok_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !char_ev |-> m_axis_tdata[7:0] == 8'd0)
        else $error("token byte on non-char event");

    // held-back blanks only on value chars
    a_blanks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != EV_VAL_CHAR |-> m_axis_tdata[17:8] == '0)
        else $error("blank count on wrong event");

    // no input stall while the result side is empty
    a_in_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("request stalled with empty result side");

endmodule

bind ini_line_lexer_core ill_checker u_ill_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
